FILE: rtl/core/ccpb_pkg.sv
// Shared types and constants for the clipped, color-keyed pixel blit.
// Holds the register map, conversion modes, configuration and queue entry types.
// No dependencies.
package ccpb_pkg;

  localparam int RAW_W    = 24;
  localparam int INDEX_W  = 23;
  localparam int WORD_W   = 32;
  localparam int BE_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;
  localparam int COUNT_W  = 11;
  localparam int POS_W    = 12;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PICTURE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PICTURE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_BOTTOM    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERSION     = 3'd7;

  typedef enum logic [1:0] {
    MODE_565_TO_565  = 2'd0,
    MODE_565_TO_8888 = 2'd1,
    MODE_888_TO_8888 = 2'd2,
    MODE_NONE        = 2'd3
  } mode_t;

  localparam logic [15:0] GREEN_MASK = 16'h07e0;
  localparam logic [15:0] BLUE_MASK  = 16'h001f;

  localparam logic [BE_W-1:0] BE_16BIT = 4'h3;
  localparam logic [BE_W-1:0] BE_32BIT = 4'h7;

  typedef struct packed {
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic [10:0]        picture_width;
    logic [10:0]        picture_height;
    logic [11:0]        frame_width;
    logic [11:0]        band_top;
    logic [12:0]        band_bottom;
    mode_t              mode;
  } cfg_t;

  typedef struct packed {
    logic [POS_W:0]    rel_row;
    logic [POS_W-1:0]  column;
    logic [WORD_W-1:0] word;
    logic [BE_W-1:0]   byte_en;
  } job_t;

endpackage

FILE: rtl/core/ccpb_if.sv
// Valid/ready channel interfaces for the pixel blit's source and write streams.
// Depends on ccpb_pkg for field widths.
interface ccpb_in_if import ccpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   raw_pixel;
  logic               frame_begin;

  modport source (output valid, output raw_pixel, output frame_begin, input ready);
  modport sink   (input valid, input raw_pixel, input frame_begin, output ready);
endinterface

interface ccpb_out_if import ccpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pixel_index;
  logic [WORD_W-1:0]  write_word;
  logic [BE_W-1:0]    byte_enables;

  modport source (output valid, output pixel_index, output write_word,
                  output byte_enables, input ready);
  modport sink   (input valid, input pixel_index, input write_word,
                  input byte_enables, output ready);
endinterface

FILE: rtl/core/ccpb_front.sv
// Front end: accepts source pixels, tracks image position, clips, keys and converts.
// Pushes one job per surviving pixel into the queue. Depends on ccpb_pkg, ccpb_in_if.
module ccpb_front import ccpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  ccpb_in_if.sink    in_px,
  input  logic       queue_full,
  output logic       push_valid,
  output job_t       push_data
);

  logic [COUNT_W-1:0] col_r, col_nxt;
  logic [COUNT_W-1:0] row_r, row_nxt;
  logic [COUNT_W-1:0] col_eff, row_eff, col_inc;
  logic signed [13:0] fx, fy, rel;
  logic               accept, in_window, key_ok;
  logic [7:0]         b0, b1, b2;
  logic [15:0]        p565;
  logic [WORD_W-1:0]  word;
  logic [BE_W-1:0]    byte_en;

  assign in_px.ready = !queue_full;
  assign accept      = in_px.valid && in_px.ready;

  assign col_eff = in_px.frame_begin ? '0 : col_r;
  assign row_eff = in_px.frame_begin ? '0 : row_r;

  assign fx  = $signed({cfg.origin_x[12], cfg.origin_x}) + $signed({3'b000, col_eff});
  assign fy  = $signed({cfg.origin_y[12], cfg.origin_y}) + $signed({3'b000, row_eff});
  assign rel = fy - $signed({2'b00, cfg.band_top});

  assign in_window = (col_eff < cfg.picture_width) && (row_eff < cfg.picture_height) &&
                     !fx[13] && (fx < $signed({2'b00, cfg.frame_width})) &&
                     (fy >= $signed({2'b00, cfg.band_top})) &&
                     (fy < $signed({1'b0, cfg.band_bottom}));

  assign b0   = in_px.raw_pixel[7:0];
  assign b1   = in_px.raw_pixel[15:8];
  assign b2   = in_px.raw_pixel[23:16];
  assign p565 = {b0, b1};

  always_comb begin
    word    = '0;
    byte_en = '0;
    key_ok  = 1'b0;
    unique case (cfg.mode)
      MODE_565_TO_565: begin
        word    = {16'h0000, b1, b0};
        byte_en = BE_16BIT;
        key_ok  = ({b1, b0} != 16'h0000);
      end
      MODE_565_TO_8888: begin
        word    = {8'h00, p565[15:11], 3'b000,
                   6'((p565 & GREEN_MASK) >> 5), 2'b00,
                   5'(p565 & BLUE_MASK), 3'b000};
        byte_en = BE_32BIT;
        key_ok  = (p565 != 16'h0000);
      end
      MODE_888_TO_8888: begin
        word    = {8'h00, b2, b1, b0};
        byte_en = BE_32BIT;
        key_ok  = (in_px.raw_pixel != '0);
      end
      MODE_NONE: begin
        key_ok = 1'b0;
      end
      default: begin
        key_ok = 1'b0;
      end
    endcase
  end

  assign push_valid        = accept && in_window && key_ok;
  assign push_data.rel_row = rel[POS_W:0];
  assign push_data.column  = fx[POS_W-1:0];
  assign push_data.word    = word;
  assign push_data.byte_en = byte_en;

  assign col_inc = col_eff + 11'd1;

  always_comb begin
    col_nxt = col_eff;
    row_nxt = row_eff;
    if (cfg.picture_width != '0) begin
      if ((col_inc >= cfg.picture_width) || (col_inc == '0)) begin
        col_nxt = '0;
        row_nxt = (row_eff == '1) ? row_eff : row_eff + 11'd1;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: rtl/core/ccpb_queue.sv
// Short FIFO of converted write jobs between the front and back ends.
// Depends on ccpb_pkg for the job type.
module ccpb_queue import ccpb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/ccpb_back.sv
// Back end: turns a queued job into a framebuffer write with its pixel index.
// One multiply and add into the output register. Depends on ccpb_pkg, ccpb_out_if.
module ccpb_back import ccpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [11:0] frame_width,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  ccpb_out_if.source out_wr
);

  logic               valid_r;
  logic [INDEX_W-1:0] index_r;
  logic [WORD_W-1:0]  word_r;
  logic [BE_W-1:0]    be_r;
  logic [INDEX_W-1:0] offset;

  assign job_pop = job_valid && (!valid_r || out_wr.ready);
  assign offset  = INDEX_W'(job.rel_row) * INDEX_W'(frame_width) + INDEX_W'(job.column);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (job_pop) begin
      valid_r <= 1'b1;
    end else if (out_wr.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      index_r <= offset;
      word_r  <= job.word;
      be_r    <= job.byte_en;
    end
  end

  assign out_wr.valid        = valid_r;
  assign out_wr.pixel_index  = index_r;
  assign out_wr.write_word   = word_r;
  assign out_wr.byte_enables = be_r;

endmodule

FILE: rtl/core/clipped_color_keyed_pixel_blit.sv
// Top level of the clipped, color-keyed pixel blit: register file, front, queue, back.
// Depends on ccpb_pkg, ccpb_if, ccpb_front, ccpb_queue and ccpb_back.
//
//   channel  direction  handshake        payload
//   in_px    sink       valid / ready    raw_pixel, frame_begin
//   out_wr   source     valid / ready    pixel_index, write_word, byte_enables
//   cfg_*    write      cfg_we           cfg_index, cfg_wdata
//
// One pixel is accepted per cycle while the queue is not full; each job passes the queue
// and the back end's output register before out_wr.valid rises. The front end classifies
// in the accepting cycle; the back end's multiply-add fills the output register. Reset is
// synchronous: it clears counters, queue and settings (but frame width 1, mode MODE_NONE).
// A stall on out_wr fills the queue; in_px.ready drops only when the queue is full.
module clipped_color_keyed_pixel_blit import ccpb_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ccpb_in_if.sink              in_px,
  ccpb_out_if.source           out_wr,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic q_full, q_push, q_pop, q_not_empty;
  job_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x       <= '0;
      cfg_r.origin_y       <= '0;
      cfg_r.picture_width  <= '0;
      cfg_r.picture_height <= '0;
      cfg_r.frame_width    <= 12'd1;
      cfg_r.band_top       <= '0;
      cfg_r.band_bottom    <= '0;
      cfg_r.mode           <= MODE_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:       cfg_r.origin_x       <= $signed(cfg_wdata);
        REG_ORIGIN_Y:       cfg_r.origin_y       <= $signed(cfg_wdata);
        REG_PICTURE_WIDTH:  cfg_r.picture_width  <= cfg_wdata[10:0];
        REG_PICTURE_HEIGHT: cfg_r.picture_height <= cfg_wdata[10:0];
        REG_FRAME_WIDTH:    cfg_r.frame_width    <= cfg_wdata[11:0];
        REG_BAND_TOP:       cfg_r.band_top       <= cfg_wdata[11:0];
        REG_BAND_BOTTOM:    cfg_r.band_bottom    <= cfg_wdata;
        REG_CONVERSION:     cfg_r.mode           <= mode_t'(cfg_wdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  ccpb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_px      (in_px),
    .queue_full (q_full),
    .push_valid (q_push),
    .push_data  (q_in)
  );

  ccpb_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_data   (q_out)
  );

  ccpb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_width (cfg_r.frame_width),
    .job_valid   (q_not_empty),
    .job         (q_out),
    .job_pop     (q_pop),
    .out_wr      (out_wr)
  );

endmodule

FILE: tb/sv/tb_clipped_color_keyed_pixel_blit.sv
// Self-checking testbench for clipped_color_keyed_pixel_blit: a directed table, then random phases.
// It predicts each framebuffer write from its own copy of the registers and the raster
// position, or takes it from a typed directed row. Depends on ccpb_pkg, ccpb_if and the block's RTL.
module tb_clipped_color_keyed_pixel_blit import ccpb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTS    = 50;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  word;
    logic [BE_W-1:0]    be;
  } blit_write_t;

  localparam blit_write_t NO_WRITE = '0;

  typedef struct {
    logic             setup;
    cfg_t             cfg;
    logic [RAW_W-1:0] raw;
    logic             fb;
    logic             typed;
    blit_write_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  ccpb_in_if  in_if ();
  ccpb_out_if out_if ();

  clipped_color_keyed_pixel_blit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_if),
    .out_wr    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t              shadow_cfg;
  logic [COUNT_W-1:0] col_pos;
  logic [COUNT_W-1:0] row_pos;
  blit_write_t       pending_writes[$];
  stim_row_t         directed_rows[$];
  blit_write_t       oldest;

  int mismatches = 0;
  int items_sent = 0;
  int writes_checked = 0;
  int settings_written = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  logic hold_token = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic cfg_t make_cfg(input int ox, input int oy, input int pw, input int ph,
                                    input int fw, input int bt, input int bb, input mode_t m);
    cfg_t c;
    c.origin_x       = 13'(ox);
    c.origin_y       = 13'(oy);
    c.picture_width  = 11'(pw);
    c.picture_height = 11'(ph);
    c.frame_width    = 12'(fw);
    c.band_top       = 12'(bt);
    c.band_bottom    = 13'(bb);
    c.mode           = m;
    return c;
  endfunction

  function automatic blit_write_t write_of(input int idx, input logic [WORD_W-1:0] word,
                                           input logic [BE_W-1:0] be);
    blit_write_t w;
    w.hit  = 1'b1;
    w.idx  = INDEX_W'(idx);
    w.word = word;
    w.be   = be;
    return w;
  endfunction

  function automatic void add_setup(input cfg_t c);
    stim_row_t r;
    r = '{setup: 1'b1, cfg: c, raw: '0, fb: 1'b0, typed: 1'b0, want: NO_WRITE};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pixel(input logic [RAW_W-1:0] raw, input logic fb,
                                    input logic typed, input blit_write_t want);
    stim_row_t r;
    r = '{setup: 1'b0, cfg: '0, raw: raw, fb: fb, typed: typed, want: want};
    directed_rows.push_back(r);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return '0;
      1: return {r[7:0], 16'h0000};
      2: return {16'h0000, r[7:0]};
      default: return r[RAW_W-1:0];
    endcase
  endfunction

  function automatic blit_write_t predict_pixel(input logic [RAW_W-1:0] raw, input logic fb);
    blit_write_t w;
    int fx, fy, fw, bt, bb, rel;
    logic [15:0] p;
    w = NO_WRITE;
    if (fb) begin
      col_pos = '0;
      row_pos = '0;
    end
    if (shadow_cfg.picture_width != 0) begin
      fx = int'(shadow_cfg.origin_x);
      fy = int'(shadow_cfg.origin_y);
      fx = fx + int'(col_pos);
      fy = fy + int'(row_pos);
      fw = int'(shadow_cfg.frame_width);
      bt = int'(shadow_cfg.band_top);
      bb = int'(shadow_cfg.band_bottom);
      if (col_pos < shadow_cfg.picture_width && row_pos < shadow_cfg.picture_height &&
          fx >= 0 && fx < fw && fy >= bt && fy < bb) begin
        case (shadow_cfg.mode)
          MODE_565_TO_565: begin
            w.word = {16'h0000, raw[15:0]};
            w.be   = BE_16BIT;
            w.hit  = raw[15:0] != 0;
          end
          MODE_565_TO_8888: begin
            p      = {raw[7:0], raw[15:8]};
            w.word = {8'h00, p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
            w.be   = BE_32BIT;
            w.hit  = p != 0;
          end
          MODE_888_TO_8888: begin
            w.word = {8'h00, raw};
            w.be   = BE_32BIT;
            w.hit  = raw != 0;
          end
          default: w.hit = 1'b0;
        endcase
        rel   = fy - bt;
        w.idx = INDEX_W'(rel * fw + fx);
      end
      col_pos = col_pos + COUNT_W'(1);
      if (col_pos >= shadow_cfg.picture_width || col_pos == 0) begin
        col_pos = '0;
        if (row_pos != {COUNT_W{1'b1}}) row_pos = row_pos + COUNT_W'(1);
      end
    end
    if (!w.hit) w = NO_WRITE;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ORIGIN_X:       shadow_cfg.origin_x = data;
      REG_ORIGIN_Y:       shadow_cfg.origin_y = data;
      REG_PICTURE_WIDTH:  shadow_cfg.picture_width = data[10:0];
      REG_PICTURE_HEIGHT: shadow_cfg.picture_height = data[10:0];
      REG_FRAME_WIDTH:    shadow_cfg.frame_width = data[11:0];
      REG_BAND_TOP:       shadow_cfg.band_top = data[11:0];
      REG_BAND_BOTTOM:    shadow_cfg.band_bottom = data;
      REG_CONVERSION:     shadow_cfg.mode = mode_t'(data[1:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(REG_ORIGIN_X, c.origin_x);
    write_reg(REG_ORIGIN_Y, c.origin_y);
    write_reg(REG_PICTURE_WIDTH, CFG_DAT_W'(c.picture_width));
    write_reg(REG_PICTURE_HEIGHT, CFG_DAT_W'(c.picture_height));
    write_reg(REG_FRAME_WIDTH, CFG_DAT_W'(c.frame_width));
    write_reg(REG_BAND_TOP, CFG_DAT_W'(c.band_top));
    write_reg(REG_BAND_BOTTOM, c.band_bottom);
    write_reg(REG_CONVERSION, CFG_DAT_W'(c.mode));
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input logic [RAW_W-1:0] raw, input logic fb, input logic typed,
                            input blit_write_t want);
    blit_write_t w;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.raw_pixel   <= raw;
    in_if.frame_begin <= fb;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    w = predict_pixel(raw, fb);
    if (typed) w = want;
    if (w.hit) pending_writes.push_back(w);
    items_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len - 1;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected write", 32'(out_if.pixel_index), '0);
      end else begin
        oldest = pending_writes.pop_front();
        writes_checked++;
        if (out_if.pixel_index !== oldest.idx)
          report_mismatch("pixel_index", 32'(out_if.pixel_index), 32'(oldest.idx));
        if (out_if.write_word !== oldest.word)
          report_mismatch("write_word", out_if.write_word, oldest.word);
        if (out_if.byte_enables !== oldest.be)
          report_mismatch("byte_enables", 32'(out_if.byte_enables), 32'(oldest.be));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run stopped after %0d cycles without finishing", LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    stim_row_t r;
    logic fb;
    int phase, n, pos, extra, frame_len, drain;

    in_if.valid       = 1'b0;
    in_if.raw_pixel   = '0;
    in_if.frame_begin = 1'b0;
    shadow_cfg = make_cfg(0, 0, 0, 0, 1, 0, 0, MODE_NONE);
    col_pos = '0;
    row_pos = '0;

    add_pixel(24'hFFFFFF, 1'b1, 1'b1, NO_WRITE);
    add_setup(make_cfg(0, 0, 4, 2, 8, 0, 8, MODE_565_TO_565));
    add_pixel(24'h12ABCD, 1'b1, 1'b1, write_of(0, 32'h0000ABCD, BE_16BIT));
    add_pixel(24'hFF0000, 1'b0, 1'b1, NO_WRITE);
    add_pixel(24'hFFFFFF, 1'b0, 1'b1, write_of(2, 32'h0000FFFF, BE_16BIT));
    add_pixel(24'h000001, 1'b0, 1'b1, write_of(3, 32'h00000001, BE_16BIT));
    add_pixel(24'h123456, 1'b0, 1'b1, write_of(8, 32'h00003456, BE_16BIT));
    add_pixel(24'h00FFFF, 1'b0, 1'b0, NO_WRITE);
    add_pixel(24'h5A5AA5, 1'b0, 1'b0, NO_WRITE);
    add_pixel(24'hA5C33C, 1'b0, 1'b0, NO_WRITE);
    add_pixel(24'hFFFFFF, 1'b0, 1'b1, NO_WRITE);
    add_setup(make_cfg(-1, 0, 4, 4, 2, 0, 4, MODE_565_TO_8888));
    add_pixel(24'h00FFFF, 1'b1, 1'b1, NO_WRITE);
    add_pixel(24'h0000F8, 1'b0, 1'b1, write_of(0, 32'h00F80000, BE_32BIT));
    add_pixel(24'h00E007, 1'b0, 1'b0, NO_WRITE);
    add_pixel(24'hFFFFFF, 1'b0, 1'b0, NO_WRITE);
    add_setup(make_cfg(0, 4095, 2047, 2047, 2048, 4095, 4096, MODE_888_TO_8888));
    add_pixel(24'hFFFFFF, 1'b1, 1'b1, write_of(0, 32'h00FFFFFF, BE_32BIT));
    add_pixel(24'h000000, 1'b0, 1'b1, NO_WRITE);
    add_pixel(24'h010000, 1'b0, 1'b1, write_of(2, 32'h00010000, BE_32BIT));
    add_pixel(24'h000080, 1'b0, 1'b0, NO_WRITE);
    add_setup(make_cfg(0, 0, 4, 4, 8, 0, 8, MODE_NONE));
    add_pixel(24'hFFFFFF, 1'b1, 1'b1, NO_WRITE);
    add_setup(make_cfg(4000, 4095, 2047, 1, 4095, 0, 4096, MODE_888_TO_8888));
    add_pixel(24'h123456, 1'b1, 1'b0, NO_WRITE);
    add_pixel(24'h800001, 1'b0, 1'b0, NO_WRITE);
    add_setup(make_cfg(-4096, -4096, 1, 2047, 0, 0, 0, MODE_565_TO_565));
    add_pixel(24'hFFFFFF, 1'b1, 1'b1, NO_WRITE);
    add_pixel(24'h7FFFFF, 1'b0, 1'b1, NO_WRITE);
    add_setup(make_cfg(0, 0, 0, 4, 8, 0, 8, MODE_565_TO_565));
    add_pixel(24'h00FFFF, 1'b1, 1'b1, NO_WRITE);
    add_pixel(24'h000001, 1'b0, 1'b1, NO_WRITE);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.setup) begin
        wait_idle();
        write_config(r.cfg);
      end else begin
        send_pixel(r.raw, r.fb, r.typed, r.want);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      if ($urandom_range(3) == 0) begin
        for (int k = 0; k <= REG_CONVERSION; k++) begin
          write_reg(CFG_IDX_W'(k), CFG_DAT_W'($urandom));
        end
        cfg_we <= 1'b0;
        settings_written++;
      end else begin
        c.picture_width  = 11'($urandom_range(1, 12));
        c.picture_height = 11'($urandom_range(1, 6));
        c.frame_width    = ($urandom_range(9) == 0) ? 12'd2048 : 12'($urandom_range(1, 40));
        c.origin_x       = 13'(int'($urandom_range(20)) - 6);
        c.band_top       = 12'($urandom_range(0, 20));
        c.origin_y       = 13'(int'(c.band_top) + int'($urandom_range(8)) - 3);
        c.band_bottom    = 13'(c.band_top) + 13'($urandom_range(1, 10));
        c.mode           = ($urandom_range(7) == 0) ? MODE_NONE : mode_t'($urandom_range(2));
        write_config(c);
      end
      frame_len = int'(shadow_cfg.picture_width) * int'(shadow_cfg.picture_height);
      pos = ($urandom_range(2) == 0) ? 1 : 0;
      extra = $urandom_range(3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase % 3 == 1 && n == PHASE_ITEMS / 2) begin
          in_if.valid <= 1'b0;
          do @(negedge clk); while (pending_writes.size() != 0);
        end
        fb = (pos == 0) || ($urandom_range(29) == 0);
        if (fb) pos = 0;
        pos++;
        if (pos >= frame_len + extra) begin
          pos = 0;
          extra = $urandom_range(3);
        end
        send_pixel(pick_raw(), fb, 1'b0, NO_WRITE);
      end
    end

    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    write_config(make_cfg(0, 0, 8, 8, 16, 0, 16, MODE_888_TO_8888));
    hold_len   <= HOLD_CYCLES;
    hold_token <= ~hold_token;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      send_pixel(pick_raw() | 24'h000001, n == 0, 1'b0, NO_WRITE);
    end

    in_if.valid <= 1'b0;
    drain = 0;
    while (pending_writes.size() != 0 && drain < 20000) begin
      @(negedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_writes.size() != 0)
      report_mismatch("writes never seen", pending_writes.size(), '0);

    $display("Sent %0d pixels under %0d register settings and checked %0d framebuffer writes,",
             items_sent, settings_written, writes_checked);
    $display("with free flow, sender gaps, receiver stalls, a long hold-off and a full drain.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: clipped_color_keyed_pixel_blit.f
rtl/core/ccpb_pkg.sv
rtl/core/ccpb_if.sv
rtl/core/ccpb_front.sv
rtl/core/ccpb_queue.sv
rtl/core/ccpb_back.sv
rtl/core/clipped_color_keyed_pixel_blit.sv
tb/sv/tb_clipped_color_keyed_pixel_blit.sv
